FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: rtl/efrm_pkg.sv
// ----------------------------------------------------------------------------
// efrm_pkg
// Types and constants of the effective frequency ratio meter.
// ----------------------------------------------------------------------------
`default_nettype none

package efrm_pkg;

   localparam int COUNT_W = 64;
   localparam int RATIO_W = 32;
   localparam int ALU_W   = COUNT_W + 1;
   localparam int STEP_W  = 6;

   localparam logic [RATIO_W-1:0] NO_FEEDBACK_CODE = 32'hFFFF_FFFF;

   // Largest delta whose product with 1000 still fits in 64 bits.
   localparam logic [COUNT_W-1:0] PERMILLE_LIMIT = 64'd18446744073709551;

   // 1000 = 1024 - 16 - 8
   localparam int MUL_SHIFT_HI  = 10;
   localparam int MUL_SHIFT_MID = 4;
   localparam int MUL_SHIFT_LO  = 3;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_FEEDBACK_ENABLED = 1'b0;

   localparam logic KIND_OPEN    = 1'b0;
   localparam logic KIND_MEASURE = 1'b1;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             no_borrow;
   } alu_result_type;

endpackage

`default_nettype wire

FILE: rtl/efrm_alu.sv
// ----------------------------------------------------------------------------
// efrm_alu
// Shared 65-bit subtractor used for deltas, compares, the x1000 scaling,
// the restoring divide steps and the saturation check.
// ----------------------------------------------------------------------------
`default_nettype none

module efrm_alu
   import efrm_pkg::*;
(
   input  wire logic [ALU_W-1:0] op_a,
   input  wire logic [ALU_W-1:0] op_b,
   output alu_result_type        result
);

   logic [ALU_W:0] sum;

   // a - b as a + ~b + 1; the carry out is set when no borrow occurs.
   assign sum = {1'b0, op_a} + {1'b0, ~op_b} + {{ALU_W{1'b0}}, 1'b1};

   assign result.diff      = sum[ALU_W-1:0];
   assign result.no_borrow = sum[ALU_W];

endmodule

`default_nettype wire

FILE: rtl/efrm_csr.sv
// ----------------------------------------------------------------------------
// efrm_csr
// APB-style register port holding the feedback enable bit.
// ----------------------------------------------------------------------------
`default_nettype none

module efrm_csr
   import efrm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic                       feedback_enabled
);

   logic feedback_enabled_ff;
   logic feedback_enabled_in;
   logic write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == REG_FEEDBACK_ENABLED);

   always_comb begin
      feedback_enabled_in = feedback_enabled_ff;
      if (write_hit) begin
         feedback_enabled_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feedback_enabled_ff <= 1'b0;
      end else begin
         feedback_enabled_ff <= feedback_enabled_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == REG_FEEDBACK_ENABLED) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, feedback_enabled_ff};
      end
   end

   assign feedback_enabled = feedback_enabled_ff;

endmodule

`default_nettype wire

FILE: rtl/efrm_core.sv
// ----------------------------------------------------------------------------
// efrm_core
// Window state, measurement sequencer around the shared subtractor, and the
// result output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module efrm_core
   import efrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               feedback_enabled,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [COUNT_W-1:0] req_actual_count,
   input  wire logic [COUNT_W-1:0] req_reference_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [RATIO_W-1:0] rsp_ratio_permille,
   output logic                    rsp_no_feedback
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUB_A,
      ST_SUB_R,
      ST_HALVE,
      ST_MUL0,
      ST_MUL1,
      ST_DIV,
      ST_SAT,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic               window_open_ff, window_open_in;
   logic [COUNT_W-1:0] start_actual_ff, start_actual_in;
   logic [COUNT_W-1:0] start_reference_ff, start_reference_in;
   logic [COUNT_W-1:0] a_ff, a_in;
   logic [COUNT_W-1:0] r_ff, r_in;
   logic [COUNT_W-1:0] num_ff, num_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [RATIO_W-1:0] res_ratio_ff, res_ratio_in;
   logic               res_nf_ff, res_nf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATIO_W-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic               rsp_nf_ff, rsp_nf_in;

   logic [ALU_W-1:0]   op_a;
   logic [ALU_W-1:0]   op_b;
   alu_result_type     alu;
   logic               rsp_free;

   efrm_alu u_alu (
      .op_a   (op_a),
      .op_b   (op_b),
      .result (alu)
   );

   // Operand selection for the shared subtractor.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_SUB_A: begin
            op_a = {1'b0, a_ff};
            op_b = {1'b0, start_actual_ff};
         end
         ST_SUB_R: begin
            op_a = {1'b0, r_ff};
            op_b = {1'b0, start_reference_ff};
         end
         ST_HALVE: begin
            op_a = {1'b0, PERMILLE_LIMIT};
            op_b = {1'b0, a_ff};
         end
         ST_MUL0: begin
            op_a = {1'b0, a_ff << MUL_SHIFT_HI};
            op_b = {1'b0, a_ff << MUL_SHIFT_MID};
         end
         ST_MUL1: begin
            op_a = {1'b0, num_ff};
            op_b = {1'b0, a_ff << MUL_SHIFT_LO};
         end
         ST_DIV: begin
            op_a = {rem_ff, num_ff[COUNT_W-1]};
            op_b = {1'b0, r_ff};
         end
         ST_SAT: begin
            op_a = {1'b0, num_ff};
            op_b = {{(ALU_W-RATIO_W){1'b0}}, NO_FEEDBACK_CODE};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in           = state_ff;
      window_open_in     = window_open_ff;
      start_actual_in    = start_actual_ff;
      start_reference_in = start_reference_ff;
      a_in               = a_ff;
      r_in               = r_ff;
      num_in             = num_ff;
      rem_in             = rem_ff;
      step_in            = step_ff;
      res_ratio_in       = res_ratio_ff;
      res_nf_in          = res_nf_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_ratio_in       = rsp_ratio_ff;
      rsp_nf_in          = rsp_nf_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_OPEN) begin
                  if (feedback_enabled) begin
                     start_actual_in    = req_actual_count;
                     start_reference_in = req_reference_count;
                     window_open_in     = 1'b1;
                  end
               end else begin
                  a_in = req_actual_count;
                  r_in = req_reference_count;
                  if (!feedback_enabled || !window_open_ff) begin
                     res_ratio_in = NO_FEEDBACK_CODE;
                     res_nf_in    = 1'b1;
                     state_in     = ST_FINISH;
                  end else begin
                     state_in = ST_SUB_A;
                  end
               end
            end
         end
         ST_SUB_A: begin
            a_in     = alu.diff[COUNT_W-1:0];
            state_in = ST_SUB_R;
         end
         ST_SUB_R: begin
            r_in     = alu.diff[COUNT_W-1:0];
            state_in = ST_HALVE;
         end
         ST_HALVE: begin
            // A zero reference delta ends in no feedback whenever it shows up;
            // further halving could never make it nonzero again.
            if (r_ff == '0) begin
               res_ratio_in = NO_FEEDBACK_CODE;
               res_nf_in    = 1'b1;
               state_in     = ST_FINISH;
            end else if (!alu.no_borrow) begin
               a_in = a_ff >> 1;
               r_in = r_ff >> 1;
            end else begin
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            num_in   = alu.diff[COUNT_W-1:0];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            num_in   = alu.diff[COUNT_W-1:0];
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring divide: the dividend shifts out of num while the
            // quotient bits shift in behind it.
            if (alu.no_borrow) begin
               rem_in = alu.diff[COUNT_W-1:0];
            end else begin
               rem_in = {rem_ff[COUNT_W-2:0], num_ff[COUNT_W-1]};
            end
            num_in  = {num_ff[COUNT_W-2:0], alu.no_borrow};
            step_in = step_ff + {{(STEP_W-1){1'b0}}, 1'b1};
            if (step_ff == {STEP_W{1'b1}}) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            res_nf_in = 1'b0;
            if (alu.no_borrow) begin
               res_ratio_in = NO_FEEDBACK_CODE - {{(RATIO_W-1){1'b0}}, 1'b1};
            end else begin
               res_ratio_in = num_ff[RATIO_W-1:0];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ratio_in = res_ratio_ff;
               rsp_nf_in    = res_nf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_open_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         window_open_ff <= window_open_in;
         rsp_valid_ff   <= rsp_valid_in;
         step_ff        <= step_in;
      end
      start_actual_ff    <= start_actual_in;
      start_reference_ff <= start_reference_in;
      a_ff               <= a_in;
      r_ff               <= r_in;
      num_ff             <= num_in;
      rem_ff             <= rem_in;
      res_ratio_ff       <= res_ratio_in;
      res_nf_ff          <= res_nf_in;
      rsp_ratio_ff       <= rsp_ratio_in;
      rsp_nf_ff          <= rsp_nf_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ratio_permille = rsp_ratio_ff;
   assign rsp_no_feedback    = rsp_nf_ff;

   `ASSERT_NEXT(a_disabled_measure_skips, clock, reset, state_ff == ST_IDLE && req_valid && req_kind == KIND_MEASURE && !feedback_enabled, state_ff == ST_FINISH)
   `ASSERT_IMPLIES(a_div_rem_below_divisor, clock, reset, state_ff == ST_DIV, rem_ff < r_ff)
   `ASSERT_IMPLIES(a_scaling_operands_ok, clock, reset, state_ff == ST_MUL0, r_ff != '0 && a_ff <= PERMILLE_LIMIT)
   `ASSERT_IMPLIES(a_no_feedback_code, clock, reset, rsp_valid_ff && rsp_nf_ff, rsp_ratio_ff == NO_FEEDBACK_CODE)

endmodule

`default_nettype wire

FILE: rtl/effective_frequency_ratio_meter_unit.sv
// Open word: no result; the core stays idle and takes the next word the following cycle.
// Measure word: 0 to 10 halving steps, the x1000 scaling, the 64-step restoring divide and
// the saturation check run on the one shared 65-bit subtractor before the result register
// loads; the next word follows ST_FINISH, later while a stalled result holds the output.
// Measure with feedback disabled or no open window: no-feedback result, no subtractor steps.
// Synchronous active-high reset closes the window, clears feedback enable and the output.
// ----------------------------------------------------------------------------
// effective_frequency_ratio_meter_unit
// Measures delivered-clock over nominal-clock counter increases in permille.
// ----------------------------------------------------------------------------
`default_nettype none

module effective_frequency_ratio_meter_unit
   import efrm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [COUNT_W-1:0]    req_actual_count,
   input  wire logic [COUNT_W-1:0]    req_reference_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [RATIO_W-1:0]    rsp_ratio_permille,
   output logic                       rsp_no_feedback,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic feedback_enabled;

   efrm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .feedback_enabled (feedback_enabled)
   );

   efrm_core u_core (
      .clock               (clock),
      .reset               (reset),
      .feedback_enabled    (feedback_enabled),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_actual_count    (req_actual_count),
      .req_reference_count (req_reference_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ratio_permille  (rsp_ratio_permille),
      .rsp_no_feedback     (rsp_no_feedback)
   );

endmodule

`default_nettype wire

FILE: tb/effective_frequency_ratio_meter_unit_tb.sv
// ----------------------------------------------------------------------------
// effective_frequency_ratio_meter_unit_tb
// Drives open and measure words into the ratio meter, predicts each permille
// result from its own copy of the window and enable state, and compares every
// delivered result field by field, under random idling and stall pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module effective_frequency_ratio_meter_unit_tb;
   import efrm_pkg::*;

   localparam logic [COUNT_W-1:0] CNT_ONES      = '1;
   localparam logic [COUNT_W-1:0] HALVING_BOUND = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;
   localparam logic [RATIO_W-1:0] SAT_RATIO     = NO_FEEDBACK_CODE - 1;
   localparam int OPEN_SETTLE   = 4;
   localparam int HOLD_CYCLES   = 600;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_WORDS   = 125;
   localparam int N_DIRECTED    = 23;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic               no_fb;
   } ratio_result_type;

   typedef enum bit {ROW_WORD, ROW_CSR} row_step_type;

   typedef struct packed {
      row_step_type       step;
      bit                 fb_value;
      logic               kind;
      logic [COUNT_W-1:0] act_cnt;
      logic [COUNT_W-1:0] nom_cnt;
      bit                 typed;
      logic [RATIO_W-1:0] exp_ratio;
      logic               exp_no_fb;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [COUNT_W-1:0]    req_actual_count;
   logic [COUNT_W-1:0]    req_reference_count;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [RATIO_W-1:0]    rsp_ratio_permille;
   logic                  rsp_no_feedback;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state.
   bit                 fb_enabled;
   bit                 win_open;
   logic [COUNT_W-1:0] win_actual;
   logic [COUNT_W-1:0] win_nominal;

   ratio_result_type ratio_expected_q [$];
   int               mismatches;
   int               scored_words;
   int               send_idle_pct;
   int               recv_idle_pct;
   bit               hold_request;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'd0, 64'd0, 1'b1, NO_FEEDBACK_CODE, 1'b1},
      '{ROW_WORD, 1'b0, KIND_OPEN, 64'd5, 64'd3, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'd10, 64'd9, 1'b1, NO_FEEDBACK_CODE, 1'b1},
      '{ROW_CSR, 1'b1, KIND_OPEN, 64'd0, 64'd0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'd7, 64'd7, 1'b1, NO_FEEDBACK_CODE, 1'b1},
      '{ROW_WORD, 1'b0, KIND_OPEN, 64'd0, 64'd0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, CNT_ONES, 64'd0, 1'b1, NO_FEEDBACK_CODE, 1'b1},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'd1000, 64'd1000, 1'b1, 32'd1000, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'd0, 64'd5, 1'b1, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, CNT_ONES, 64'd1, 1'b1, NO_FEEDBACK_CODE, 1'b1},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'd5000000, 64'd1, 1'b1, SAT_RATIO, 1'b0},
      '{ROW_WORD, 1'b0, KIND_OPEN, CNT_ONES, CNT_ONES, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'd3, 64'd1, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, CNT_ONES, 64'hFFFF_FFFF_FFFF_FFFE,
        1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_OPEN, 64'h8000_0000_0000_0000, 64'd0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'h7FFF_FFFF_FFFF_FFFF, CNT_ONES,
        1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'h8123_4567_89AB_CDEF, 64'h0000_0000_FFFF_FFFF,
        1'b0, 32'd0, 1'b0},
      '{ROW_CSR, 1'b0, KIND_OPEN, 64'd0, 64'd0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_OPEN, 64'd5, 64'd5, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'd6, 64'd6, 1'b1, NO_FEEDBACK_CODE, 1'b1},
      '{ROW_CSR, 1'b1, KIND_OPEN, 64'd0, 64'd0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'h8000_0000_0001_0000, 64'h0000_0000_0000_8000,
        1'b0, 32'd0, 1'b0},
      '{ROW_WORD, 1'b0, KIND_MEASURE, 64'hA5A5_5A5A_F0F0_0F0F, 64'h5A5A_A5A5_0F0F_F0F0,
        1'b0, 32'd0, 1'b0}
   };

   effective_frequency_ratio_meter_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_actual_count    (req_actual_count),
      .req_reference_count (req_reference_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ratio_permille  (rsp_ratio_permille),
      .rsp_no_feedback     (rsp_no_feedback),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [COUNT_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Returns 1 when the word produces a result; an enabled open word updates the window.
   function automatic bit predict_ratio(input logic kind, input logic [COUNT_W-1:0] act_cnt,
                                        input logic [COUNT_W-1:0] nom_cnt,
                                        output ratio_result_type res);
      logic [COUNT_W-1:0] d_act;
      logic [COUNT_W-1:0] d_nom;
      logic [COUNT_W-1:0] quot;
      res.ratio = NO_FEEDBACK_CODE;
      res.no_fb = 1'b1;
      if (kind == KIND_OPEN) begin
         if (fb_enabled) begin
            win_actual  = act_cnt;
            win_nominal = nom_cnt;
            win_open    = 1'b1;
         end
         return 1'b0;
      end
      if (!fb_enabled || !win_open) begin
         return 1'b1;
      end
      d_act = act_cnt - win_actual;
      d_nom = nom_cnt - win_nominal;
      if (d_nom == '0) begin
         return 1'b1;
      end
      while (d_act > HALVING_BOUND) begin
         d_act = d_act >> 1;
         d_nom = d_nom >> 1;
      end
      if (d_nom == '0) begin
         return 1'b1;
      end
      quot = (d_act * 64'd1000) / d_nom;
      if (quot >= {32'd0, NO_FEEDBACK_CODE}) begin
         quot = {32'd0, SAT_RATIO};
      end
      res.ratio = quot[RATIO_W-1:0];
      res.no_fb = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic issue_word(input logic kind, input logic [COUNT_W-1:0] act_cnt,
                             input logic [COUNT_W-1:0] nom_cnt, input bit typed,
                             input logic [RATIO_W-1:0] typed_ratio, input logic typed_nf);
      ratio_result_type res;
      bit               has_res;
      has_res = predict_ratio(kind, act_cnt, nom_cnt, res);
      if (has_res) begin
         if (typed) begin
            res.ratio = typed_ratio;
            res.no_fb = typed_nf;
         end
         ratio_expected_q.push_back(res);
      end
      if (kind == KIND_MEASURE || fb_enabled) begin
         scored_words++;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_actual_count    <= act_cnt;
      req_reference_count <= nom_cnt;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (ratio_expected_q.size() != 0) begin
         @(posedge clock);
      end
      // An open word leaves no result behind, so give it time to retire.
      repeat (OPEN_SETTLE) @(negedge clock);
   endtask

   task automatic write_feedback_enable(input bit enable);
      drain_results();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= REG_FEEDBACK_ENABLED;
      csr_pwdata  <= CSR_DATA_W'(enable);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[0] !== enable) begin
         report_mismatch($sformatf("feedback_enabled reads %0b, written %0b",
                                   csr_prdata[0], enable));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      fb_enabled = enable;
   endtask

   task automatic run_random_phase(input int n_words);
      int                 target;
      logic [COUNT_W-1:0] base_act;
      logic [COUNT_W-1:0] base_nom;
      logic [COUNT_W-1:0] d_act;
      logic [COUNT_W-1:0] d_nom;
      target = scored_words + n_words;
      while (scored_words < target) begin
         if ($urandom_range(0, 4) == 0) begin
            write_feedback_enable($urandom_range(0, 5) != 0);
         end
         if ($urandom_range(0, 99) < 85) begin
            // A window followed by measures spread over every arithmetic regime.
            base_act = rand64();
            base_nom = rand64();
            issue_word(KIND_OPEN, base_act, base_nom, 1'b0, 32'd0, 1'b0);
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 9))
                  0: begin
                     d_act = COUNT_W'($urandom_range(0, 2000));
                     d_nom = COUNT_W'($urandom_range(0, 2000));
                  end
                  1, 2, 3, 4: begin
                     d_nom = rand64() >> $urandom_range(24, 63);
                     d_act = d_nom * COUNT_W'($urandom_range(300, 5000)) / 64'd1000;
                  end
                  5: begin
                     d_act = rand64();
                     d_nom = rand64();
                  end
                  6: begin
                     d_act = rand64();
                     d_nom = COUNT_W'($urandom_range(0, 3));
                  end
                  7: begin
                     d_act = rand64() >> $urandom_range(0, 63);
                     d_nom = '0;
                  end
                  8: begin
                     d_act = rand64() >> $urandom_range(0, 40);
                     d_nom = rand64() >> $urandom_range(32, 63);
                  end
                  default: begin
                     d_act = '0;
                     d_nom = rand64() >> $urandom_range(0, 63);
                  end
               endcase
               issue_word(KIND_MEASURE, base_act + d_act, base_nom + d_nom,
                          1'b0, 32'd0, 1'b0);
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               issue_word(1'($urandom_range(0, 1)), rand64(), rand64(), 1'b0, 32'd0, 1'b0);
            end
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      ratio_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ratio_expected_q.size() == 0) begin
            report_mismatch("result word with no expectation pending");
         end else begin
            want = ratio_expected_q.pop_front();
            if (rsp_ratio_permille !== want.ratio) begin
               report_mismatch($sformatf("ratio_permille %0d, expected %0d",
                                         rsp_ratio_permille, want.ratio));
            end
            if (rsp_no_feedback !== want.no_fb) begin
               report_mismatch($sformatf("no_feedback %0b, expected %0b",
                                         rsp_no_feedback, want.no_fb));
            end
         end
      end
   end

   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("effective_frequency_ratio_meter_unit: mismatch");
      $finish;
   end

   initial begin : stimulus
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_kind            = KIND_OPEN;
      req_actual_count    = '0;
      req_reference_count = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = REG_FEEDBACK_ENABLED;
      csr_pwdata          = '0;
      fb_enabled          = 1'b0;
      win_open            = 1'b0;
      win_actual          = '0;
      win_nominal         = '0;
      mismatches          = 0;
      scored_words        = 0;
      send_idle_pct       = 0;
      recv_idle_pct       = 0;
      hold_request        = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].step == ROW_CSR) begin
            write_feedback_enable(directed_rows[i].fb_value);
         end else begin
            issue_word(directed_rows[i].kind, directed_rows[i].act_cnt,
                       directed_rows[i].nom_cnt, directed_rows[i].typed,
                       directed_rows[i].exp_ratio, directed_rows[i].exp_no_fb);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 59 : 0;
         recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 17 : 0;
         if (ph == 2) begin
            // The write drains everything first; then the receiver holds off
            // while measure words keep coming until the input backs up.
            write_feedback_enable(1'b1);
            issue_word(KIND_OPEN, rand64(), rand64(), 1'b0, 32'd0, 1'b0);
            hold_request = 1'b1;
            repeat (6) begin
               issue_word(KIND_MEASURE, rand64(), rand64(), 1'b0, 32'd0, 1'b0);
            end
         end
         run_random_phase(PHASE_WORDS);
      end

      drain_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("effective_frequency_ratio_meter_unit: match");
      end else begin
         $display("effective_frequency_ratio_meter_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/efrm_pkg.sv
rtl/efrm_alu.sv
rtl/efrm_csr.sv
rtl/efrm_core.sv
rtl/effective_frequency_ratio_meter_unit.sv
tb/effective_frequency_ratio_meter_unit_tb.sv
